/* rtl/sirt_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and character helpers for the signed integer to radix text block.
// No dependencies; every other file in rtl imports this package.
package sirt_pkg;

    // Value and alphabet geometry
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int ALPHA_WORDS     = 8;
    localparam int ALPHA_WORD_W    = 64;
    localparam int ALPHA_SEL_W     = 3;
    localparam int BYTE_SEL_W      = 3;
    localparam int ALPHA_POS_W     = 6;
    localparam int CHAR_W          = 8;
    localparam int DIGIT_W         = 6;
    localparam int SEEN_W          = 1 << DIGIT_W;
    localparam int CODE_COUNT      = 62;
    localparam int MIN_RADIX       = 2;
    localparam int CFG_INDEX_W     = 8;

    // Alphabet reset: decimal digits "0123456789"
    localparam logic [ALPHA_WORD_W-1:0] ALPHA_RESET_0 = 64'h3736_3534_3332_3130;
    localparam logic [ALPHA_WORD_W-1:0] ALPHA_RESET_1 = 64'h0000_0000_0000_3938;

    // Characters
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    // Dense code offsets for the duplicate map
    localparam logic [CHAR_W-1:0] CODE_UPPER_BASE = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_LOWER_BASE = 8'd36;

    // Carry link between neighbouring digit cells
    typedef struct packed {
        logic valid;
        logic carry;
    } link_t;

    // Alphabet checker status
    typedef struct packed {
        logic               busy;
        logic               ok;
        logic [DIGIT_W-1:0] radix;
    } alpha_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGITS
    } ctl_state_t;

    function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
        return ((c >= CHAR_LA) && (c <= CHAR_LZ)) ||
               ((c >= CHAR_UA) && (c <= CHAR_UZ)) ||
               ((c >= CHAR_0)  && (c <= CHAR_9));
    endfunction

    // Maps 0-9, A-Z, a-z onto 0..61; meaningless for other characters
    function automatic logic [DIGIT_W-1:0] alnum_code(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] off;
        if (c <= CHAR_9) begin
            off = c - CHAR_0;
        end else if (c <= CHAR_UZ) begin
            off = c - CHAR_UA + CODE_UPPER_BASE;
        end else begin
            off = c - CHAR_LA + CODE_LOWER_BASE;
        end
        return off[DIGIT_W-1:0];
    endfunction

endpackage

/* rtl/sirt_cell.sv */
`timescale 1ns / 1ps
// One digit cell of the conversion chain: doubles its digit plus incoming carry modulo
// the radix, and shifts digits towards the top during output. Depends on sirt_pkg.
module sirt_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         clear,
    input  logic                         shift_en,
    input  logic [sirt_pkg::DIGIT_W-1:0] radix,
    input  sirt_pkg::link_t              link_in,
    input  logic [sirt_pkg::DIGIT_W-1:0] digit_in,
    output sirt_pkg::link_t              link_out,
    output logic [sirt_pkg::DIGIT_W-1:0] digit_out
);
    import sirt_pkg::*;

    logic [DIGIT_W-1:0] d_reg, d_next;
    link_t              link_reg, link_next;
    logic [DIGIT_W:0]   dbl;
    logic [DIGIT_W:0]   sub;
    logic               wrap;

    // 2*d + carry, folded once against the radix
    always_comb begin
        dbl  = {d_reg, link_in.carry};
        sub  = dbl - {1'b0, radix};
        wrap = (dbl >= {1'b0, radix});
    end

    always_comb begin
        priority if (clear) begin
            d_next = '0;
        end else if (shift_en) begin
            d_next = digit_in;
        end else if (link_in.valid) begin
            d_next = wrap ? sub[DIGIT_W-1:0] : dbl[DIGIT_W-1:0];
        end else begin
            d_next = d_reg;
        end

        if (clear) begin
            link_next = '0;
        end else begin
            link_next.valid = link_in.valid;
            link_next.carry = link_in.valid & wrap;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg <= '0;
        end else begin
            link_reg <= link_next;
        end
    end

    always_ff @(posedge aclk) begin
        d_reg <= d_next;
    end

    assign link_out  = link_reg;
    assign digit_out = d_reg;

endmodule

/* rtl/sirt_alpha_check.sv */
`timescale 1ns / 1ps
// Alphabet checker: walks the alphabet one byte per cycle after reset and after each
// configuration write, finding its length and rejecting bad or repeated characters. Uses sirt_pkg.
module sirt_alpha_check (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             restart,
    input  logic [sirt_pkg::CHAR_W-1:0]      rd_char,
    output logic [sirt_pkg::ALPHA_POS_W-1:0] rd_pos,
    output sirt_pkg::alpha_stat_t            stat
);
    import sirt_pkg::*;

    localparam logic [ALPHA_POS_W:0] MIN_LEN   = (ALPHA_POS_W + 1)'(MIN_RADIX);
    localparam logic [DIGIT_W-1:0]   MIN_RDX   = DIGIT_W'(MIN_RADIX);
    localparam logic [DIGIT_W-1:0]   MAX_RDX   = DIGIT_W'(CODE_COUNT);

    logic                 busy_reg, busy_next;
    logic                 ok_reg, ok_next;
    logic [DIGIT_W-1:0]   radix_reg, radix_next;
    logic [ALPHA_POS_W:0] pos_reg, pos_next;
    logic [SEEN_W-1:0]    seen_reg, seen_next;
    logic [DIGIT_W-1:0]   code;
    logic                 at_end;
    logic                 bad;

    // Character classification for the byte under the cursor
    always_comb begin
        code   = alnum_code(rd_char);
        at_end = pos_reg[ALPHA_POS_W] || (rd_char == CHAR_NUL);
        bad    = !is_alnum(rd_char) || seen_reg[code];
    end

    // Scan sequencing
    always_comb begin
        busy_next  = busy_reg;
        ok_next    = ok_reg;
        radix_next = radix_reg;
        pos_next   = pos_reg;
        seen_next  = seen_reg;
        if (restart) begin
            busy_next = 1'b1;
            ok_next   = 1'b0;
            pos_next  = '0;
            seen_next = '0;
        end else if (busy_reg) begin
            priority if (at_end) begin
                busy_next  = 1'b0;
                ok_next    = (pos_reg >= MIN_LEN);
                radix_next = pos_reg[DIGIT_W-1:0];
            end else if (bad) begin
                busy_next = 1'b0;
                ok_next   = 1'b0;
            end else begin
                seen_next[code] = 1'b1;
                pos_next        = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            ok_reg   <= 1'b0;
            pos_reg  <= '0;
            seen_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            ok_reg   <= ok_next;
            pos_reg  <= pos_next;
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        radix_reg <= radix_next;
    end

    assign rd_pos      = pos_reg[ALPHA_POS_W-1:0];
    assign stat.busy   = busy_reg;
    assign stat.ok     = ok_reg;
    assign stat.radix  = radix_reg;

    // A good alphabet always has a usable radix
    a_radix_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (!busy_reg && ok_reg) |-> ((radix_reg >= MIN_RDX) && (radix_reg <= MAX_RDX)))
        else $error("accepted alphabet with radix out of range");

    // An accepted character is remembered for the duplicate check
    a_seen_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !restart && !at_end && !bad) |=> seen_reg[$past(code)])
        else $error("scanned character not marked as seen");

    // Verdict only moves when a scan runs
    a_verdict_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (!busy_reg && !restart) |=> (!busy_reg && $stable(ok_reg) && $stable(radix_reg)))
        else $error("alphabet verdict changed without a rescan");

endmodule

/* rtl/signed_integer_to_radix_text.sv */
`timescale 1ns / 1ps
// Top level of the signed integer to radix text converter: configuration registers,
// control sequencer, digit cell chain and output register. Uses sirt_pkg, sirt_cell, sirt_alpha_check.
//
// Converts one VALUE_WIDTH-bit two's complement number into characters of the alphabet held in
// alphabet_word_0..7 (radix = count of leading nonzero bytes), '-' first for negative values,
// most significant digit first, m_final_char on the last character. An alphabet shorter than
// two characters, with a non-alphanumeric or a repeated character, makes a transaction produce
// no characters. The magnitude is shifted MSB first into a row of VALUE_WIDTH digit cells whose
// carries are registered from cell to cell; when the conversion count runs out, the digits
// shift out of the top cell at one per cycle while the output is not stalled (leading zeros
// are dropped at one per cycle without waiting on the output), after a minus sign for negative
// values. One number is in flight at a time. After reset and after each configuration write
// the alphabet is checked one byte per cycle while s_ready stays low.
module signed_integer_to_radix_text #(
    parameter int VALUE_WIDTH = sirt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [VALUE_WIDTH-1:0]     s_number,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sirt_pkg::CHAR_W-1:0]       m_text_char,
    output logic                              m_final_char,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sirt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sirt_pkg::ALPHA_WORD_W-1:0] cfg_data
);
    import sirt_pkg::*;

    localparam int CELLS       = VALUE_WIDTH;
    localparam int CONV_CYCLES = VALUE_WIDTH + CELLS - 1;
    localparam int CNT_W       = $clog2(CONV_CYCLES);
    localparam int REM_W       = $clog2(CELLS + 1);

    localparam logic [CNT_W-1:0]       CONV_LAST = CNT_W'(CONV_CYCLES - 1);
    localparam logic [CNT_W-1:0]       FEED_END  = CNT_W'(VALUE_WIDTH);
    localparam logic [REM_W-1:0]       REM_FULL  = REM_W'(CELLS);
    localparam logic [REM_W-1:0]       REM_ONE   = REM_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT = CFG_INDEX_W'(ALPHA_WORDS);

    // Configuration store
    logic [ALPHA_WORD_W-1:0] alpha_reg [ALPHA_WORDS];
    logic                    cfg_wr;

    // Sequencer state
    ctl_state_t              state_reg, state_next;
    logic [VALUE_WIDTH-1:0]  mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic                    started_reg, started_next;

    // Output register
    logic                    out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]       out_char_reg, out_char_next;
    logic                    out_final_reg, out_final_next;
    logic                    can_load;
    logic                    out_load;

    // Cell chain wiring
    link_t                   links  [CELLS+1];
    logic [DIGIT_W-1:0]      digits [CELLS+1];
    logic                    cell_clear;
    logic                    cell_shift;
    logic [DIGIT_W-1:0]      top_digit;
    logic                    feed_on;

    // Alphabet read port and checker
    alpha_stat_t             scan_stat;
    logic [ALPHA_POS_W-1:0]  scan_pos;
    logic [ALPHA_POS_W-1:0]  rd_pos;
    logic [CHAR_W-1:0]       rd_char;
    logic [VALUE_WIDTH-1:0]  raw;
    logic                    emit;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < ALPHA_WORDS; w++) begin
                alpha_reg[w] <= (w == 0) ? ALPHA_RESET_0 :
                                (w == 1) ? ALPHA_RESET_1 : '0;
            end
        end else if (cfg_wr && (cfg_index < CFG_LIMIT)) begin
            alpha_reg[cfg_index[ALPHA_SEL_W-1:0]] <= cfg_data;
        end
    end

    // Single alphabet byte read, shared by the checker and digit output
    assign top_digit = digits[CELLS];
    assign rd_pos    = (state_reg == ST_DIGITS) ? top_digit : scan_pos;
    assign rd_char   = alpha_reg[rd_pos[ALPHA_POS_W-1:BYTE_SEL_W]]
                                [CHAR_W*rd_pos[BYTE_SEL_W-1:0] +: CHAR_W];

    sirt_alpha_check u_check (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (cfg_wr),
        .rd_char (rd_char),
        .rd_pos  (scan_pos),
        .stat    (scan_stat)
    );

    // Digit cells, least significant at index 0
    assign digits[0] = '0;

    // Feed magnitude bits MSB first into the bottom cell, then let the carry wave drain
    assign feed_on  = (state_reg == ST_CONV) && (cnt_reg < FEED_END);
    assign links[0] = '{valid: feed_on, carry: feed_on & mag_reg[VALUE_WIDTH-1]};

    for (genvar j = 0; j < CELLS; j++) begin : g_cell
        sirt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .clear     (cell_clear),
            .shift_en  (cell_shift),
            .radix     (scan_stat.radix),
            .link_in   (links[j]),
            .digit_in  (digits[j]),
            .link_out  (links[j+1]),
            .digit_out (digits[j+1])
        );
    end

    // Sequencer and output register next state
    always_comb begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        started_next   = started_reg;
        cell_clear     = 1'b0;
        cell_shift     = 1'b0;
        out_load       = 1'b0;
        out_char_next  = out_char_reg;
        out_final_next = out_final_reg;
        raw            = s_number;
        can_load       = !out_valid_reg || m_ready;
        s_ready        = (state_reg == ST_IDLE) && !scan_stat.busy;
        emit           = started_reg || (top_digit != '0) || (rem_reg == REM_ONE);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready && scan_stat.ok) begin
                    neg_next     = raw[VALUE_WIDTH-1];
                    mag_next     = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
                    cnt_next     = '0;
                    rem_next     = REM_FULL;
                    started_next = 1'b0;
                    cell_clear   = 1'b1;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV: begin
                // shift the magnitude while the carry wave runs up the chain
                mag_next       = mag_reg << 1;
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == CONV_LAST) begin
                    state_next = neg_reg ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN: begin
                if (can_load) begin
                    out_load       = 1'b1;
                    out_char_next  = MINUS_CHAR;
                    out_final_next = 1'b0;
                    state_next     = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (!emit) begin
                    // leading zero: drop it
                    cell_shift = 1'b1;
                    rem_next   = rem_reg - 1'b1;
                end else if (can_load) begin
                    out_load       = 1'b1;
                    out_char_next  = rd_char;
                    out_final_next = (rem_reg == REM_ONE);
                    cell_shift     = 1'b1;
                    rem_next       = rem_reg - 1'b1;
                    started_next   = 1'b1;
                    if (rem_reg == REM_ONE) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        out_char_reg  <= out_char_next;
        out_final_reg <= out_final_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_text_char  = out_char_reg;
    assign m_final_char = out_final_reg;

    // The top cell never produces a carry: VALUE_WIDTH digits always suffice
    a_no_top_carry: assert property (@(posedge aclk) disable iff (!aresetn)
        links[CELLS].valid |-> !links[CELLS].carry)
        else $error("carry out of the top digit cell");

    // Digits reaching the output are proper digits of the radix
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIGITS) |-> (top_digit < scan_stat.radix))
        else $error("digit at the top cell not below the radix");

    // The final character ends the transaction's work
    a_final_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIGITS && out_load && out_final_next) |=> (state_reg == ST_IDLE))
        else $error("sequencer busy after final character");

    // An accepted number with a good alphabet starts conversion from count zero
    a_conv_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && scan_stat.ok) |=> (state_reg == ST_CONV && cnt_reg == '0))
        else $error("conversion did not start after acceptance");

endmodule
